// File: rtl/core/dltq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta list timer queue package
// Shared widths, command and result codes, and the request and result records.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DELTA_W     = 31;
  localparam int ACC_W       = DELTA_W + IDX_W + 1;
  localparam int PAYLOAD_W   = 32;
  localparam int PHASE_W     = 4;
  localparam int CMD_W       = 3;
  localparam int KIND_W      = 3;
  localparam int TAG_W       = 16;
  localparam int ID_W        = 8;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SCHED  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EXISTS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNTS = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ACK    = 3'd5;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PERIODIC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SCHED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXISTS   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COUNTS   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ACK      = 3'd6;

  typedef enum logic [2:0] {
    OP_TICK, OP_SCHED, OP_CANCEL, OP_EXISTS, OP_COUNTS, OP_ACK
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 core;
    logic [DELTA_W-1:0]   delay;
    logic [ID_W-1:0]      msg_id;
    logic [TAG_W-1:0]     tag;
    logic [PAYLOAD_W-1:0] payload;
    logic                 any;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 core;
    logic [ID_W-1:0]      msg_id;
    logic [TAG_W-1:0]     tag;
    logic [PAYLOAD_W-1:0] payload;
    logic [DELTA_W-1:0]   time_left;
    logic                 found;
    logic [CNT_W-1:0]     count_total;
    logic [CNT_W-1:0]     count_core0;
    logic [CNT_W-1:0]     count_core1;
    logic [CNT_W-1:0]     count_sleep;
    logic                 last;
  } res_t;

  localparam int REQ_Q_DEPTH = 2;
  localparam int REQ_PTR_W   = $clog2(REQ_Q_DEPTH);
  localparam int RES_Q_DEPTH = 4;
  localparam int RES_PTR_W   = $clog2(RES_Q_DEPTH);

endpackage

// File: rtl/core/dltq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Accepts input requests, decodes the command and queues valid ones.
// ----------------------------------------------------------------------------
module dltq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [dltq_pkg::CMD_W-1:0]     in_cmd,
  input  logic                           in_core,
  input  logic [dltq_pkg::DELTA_W-1:0]   in_delay_ms,
  input  logic [dltq_pkg::ID_W-1:0]      in_msg_id,
  input  logic [dltq_pkg::TAG_W-1:0]     in_handler_tag,
  input  logic [dltq_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic                           in_any_handler,
  output logic                           req_valid,
  output dltq_pkg::req_t                 req_data,
  input  logic                           req_pop
);
  import dltq_pkg::*;

  req_t                  mem_r [REQ_Q_DEPTH];
  logic [REQ_PTR_W-1:0]  wr_r, rd_r;
  logic [REQ_PTR_W:0]    cnt_r;
  logic                  known;
  logic                  wr_en;
  op_t                   op;

  // Decode the command; unknown codes are accepted and dropped.
  always_comb begin
    known = 1'b1;
    op    = OP_TICK;
    unique case (in_cmd)
      CMD_TICK:   op = OP_TICK;
      CMD_SCHED:  op = OP_SCHED;
      CMD_CANCEL: op = OP_CANCEL;
      CMD_EXISTS: op = OP_EXISTS;
      CMD_COUNTS: op = OP_COUNTS;
      CMD_ACK:    op = OP_ACK;
      default:    known = 1'b0;
    endcase
  end

  assign full      = (cnt_r == (REQ_PTR_W+1)'(REQ_Q_DEPTH));
  assign wr_en     = push && !full && known;
  assign req_valid = (cnt_r != '0);
  assign req_data  = mem_r[rd_r];

  // Payload storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_r] <= '{op: op, core: in_core, delay: in_delay_ms, msg_id: in_msg_id,
                       tag: in_handler_tag, payload: in_payload, any: in_any_handler};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wr_r <= wr_r + 1'b1;
      if (req_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (REQ_PTR_W+1)'(wr_en) - (REQ_PTR_W+1)'(req_pop);
    end
  end

endmodule

// File: rtl/core/dltq_res_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module dltq_res_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  dltq_pkg::res_t wr_data,
  output logic           res_full,
  output logic           empty,
  input  logic           pop,
  output dltq_pkg::res_t rd_data
);
  import dltq_pkg::*;

  res_t                  mem_r [RES_Q_DEPTH];
  logic [RES_PTR_W-1:0]  wr_r, rd_r;
  logic [RES_PTR_W:0]    cnt_r;
  logic                  do_wr, do_rd;

  assign res_full = (cnt_r == (RES_PTR_W+1)'(RES_Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_wr    = wr_en && !res_full;
  assign do_rd    = pop && !empty;
  assign rd_data  = mem_r[rd_r];

  // Payload storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_r] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wr_r <= wr_r + 1'b1;
      if (do_rd) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (RES_PTR_W+1)'(do_wr) - (RES_PTR_W+1)'(do_rd);
    end
  end

endmodule

// File: rtl/core/dltq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer list engine
// Walks the delta list one entry per cycle and carries out each request.
// ----------------------------------------------------------------------------
module dltq_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dltq_pkg::TAG_W-1:0] sleep_tag,
  input  logic                       req_valid,
  input  dltq_pkg::req_t             req_data,
  output logic                       req_pop,
  output logic                       res_valid,
  output dltq_pkg::res_t             res_data,
  input  logic                       res_full
);
  import dltq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_PER0, S_PER1, S_WALK, S_REMOVE, S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  req_t                 cur_r, cur_nxt;
  res_t                 res_r, res_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [DELTA_W-1:0]   hold_r, hold_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [1:0]           pend_r, pend_nxt;

  logic [DELTA_W-1:0]   delta_r [QUEUE_DEPTH];
  logic                 ecore_r [QUEUE_DEPTH];
  logic [ID_W-1:0]      eid_r   [QUEUE_DEPTH];
  logic [TAG_W-1:0]     etag_r  [QUEUE_DEPTH];
  logic [PAYLOAD_W-1:0] epay_r  [QUEUE_DEPTH];
  logic [DELTA_W-1:0]   delta_nxt [QUEUE_DEPTH];
  logic                 ecore_nxt [QUEUE_DEPTH];
  logic [ID_W-1:0]      eid_nxt   [QUEUE_DEPTH];
  logic [TAG_W-1:0]     etag_nxt  [QUEUE_DEPTH];
  logic [PAYLOAD_W-1:0] epay_nxt  [QUEUE_DEPTH];

  logic [IDX_W-1:0]     ia, rm;
  logic [CNT_W-1:0]     rm_w;
  logic [DELTA_W-1:0]   d_at;
  logic                 in_range, key_match;
  logic [ACC_W-1:0]     abs_sum;
  logic [DELTA_W:0]     pair_sum;
  logic                 more, per_any;

  // Entry at the walk index.
  assign ia        = idx_r[IDX_W-1:0];
  assign d_at      = delta_r[ia];
  assign in_range  = (idx_r < cnt_r);
  assign key_match = (ecore_r[ia] == cur_r.core) && (eid_r[ia] == cur_r.msg_id);
  assign abs_sum   = acc_r + ACC_W'(d_at);
  assign pair_sum  = {1'b0, d_at} + {1'b0, hold_r};
  assign rm_w      = idx_r - 1'b1;
  assign rm        = rm_w[IDX_W-1:0];
  assign more      = (cnt_r > CNT_W'(1)) && (delta_r[1] == '0);
  assign per_any   = (phase_r == '0) && (!pend_r[0] || !pend_r[1]);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    hold_nxt  = hold_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    delta_nxt = delta_r;
    ecore_nxt = ecore_r;
    eid_nxt   = eid_r;
    etag_nxt  = etag_r;
    epay_nxt  = epay_r;
    req_pop   = 1'b0;
    res_valid = 1'b0;
    res_data  = res_r;

    unique case (state_r)
      // Take a request and set up its walk.
      S_IDLE: begin
        if (req_valid) begin
          req_pop       = 1'b1;
          cur_nxt       = req_data;
          idx_nxt       = '0;
          acc_nxt       = '0;
          res_nxt       = '0;
          res_nxt.core  = req_data.core;
          res_nxt.last  = 1'b1;
          unique case (req_data.op)
            OP_TICK: begin
              phase_nxt = phase_r + 1'b1;
              if (cnt_r != '0 && delta_r[0] <= DELTA_W'(1)) begin
                delta_nxt[0] = '0;
                state_nxt    = S_EXP;
              end else begin
                if (cnt_r != '0) delta_nxt[0] = delta_r[0] - 1'b1;
                state_nxt = S_PER0;
              end
            end
            OP_SCHED: begin
              res_nxt.kind = KIND_SCHED;
              acc_nxt      = ACC_W'(req_data.delay);
              state_nxt    = (cnt_r == CNT_W'(QUEUE_DEPTH)) ? S_EMIT : S_WALK;
            end
            OP_CANCEL: begin
              res_nxt.kind = KIND_CANCEL;
              state_nxt    = S_WALK;
            end
            OP_EXISTS: begin
              res_nxt.kind = KIND_EXISTS;
              state_nxt    = S_WALK;
            end
            OP_COUNTS: begin
              res_nxt.kind = KIND_COUNTS;
              res_nxt.core = 1'b0;
              state_nxt    = S_WALK;
            end
            OP_ACK: begin
              res_nxt.kind           = KIND_ACK;
              pend_nxt[req_data.core] = 1'b0;
              state_nxt              = S_EMIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Emit the expired head entry and pull the list down by one.
      S_EXP: begin
        res_valid         = 1'b1;
        res_data          = '0;
        res_data.kind     = KIND_EXPIRED;
        res_data.core     = ecore_r[0];
        res_data.msg_id   = eid_r[0];
        res_data.tag      = etag_r[0];
        res_data.payload  = epay_r[0];
        res_data.last     = !more && !per_any;
        if (!res_full) begin
          for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            delta_nxt[j] = delta_r[j+1];
            ecore_nxt[j] = ecore_r[j+1];
            eid_nxt[j]   = eid_r[j+1];
            etag_nxt[j]  = etag_r[j+1];
            epay_nxt[j]  = epay_r[j+1];
          end
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = more ? S_EXP : S_PER0;
        end
      end

      // Periodic post to core zero.
      S_PER0: begin
        if (phase_r == '0 && !pend_r[0]) begin
          res_valid     = 1'b1;
          res_data      = '0;
          res_data.kind = KIND_PERIODIC;
          res_data.core = 1'b0;
          res_data.last = pend_r[1];
          if (!res_full) begin
            pend_nxt[0] = 1'b1;
            state_nxt   = S_PER1;
          end
        end else begin
          state_nxt = S_PER1;
        end
      end

      // Periodic post to core one.
      S_PER1: begin
        if (phase_r == '0 && !pend_r[1]) begin
          res_valid     = 1'b1;
          res_data      = '0;
          res_data.kind = KIND_PERIODIC;
          res_data.core = 1'b1;
          res_data.last = 1'b1;
          if (!res_full) begin
            pend_nxt[1] = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // One list entry per cycle.
      S_WALK: begin
        unique case (cur_r.op)
          OP_SCHED: begin
            if (in_range && acc_r > ACC_W'(d_at)) begin
              acc_nxt = acc_r - ACC_W'(d_at);
              idx_nxt = idx_r + 1'b1;
            end else begin
              // Insert ahead of the entry at the walk index.
              for (int j = 1; j < QUEUE_DEPTH; j++) begin
                if (IDX_W'(j) > ia) begin
                  delta_nxt[j] = delta_r[j-1];
                  ecore_nxt[j] = ecore_r[j-1];
                  eid_nxt[j]   = eid_r[j-1];
                  etag_nxt[j]  = etag_r[j-1];
                  epay_nxt[j]  = epay_r[j-1];
                end
                if (in_range && CNT_W'(j) == idx_r + 1'b1) begin
                  delta_nxt[j] = d_at - acc_r[DELTA_W-1:0];
                end
              end
              delta_nxt[ia] = acc_r[DELTA_W-1:0];
              ecore_nxt[ia] = cur_r.core;
              eid_nxt[ia]   = cur_r.msg_id;
              etag_nxt[ia]  = cur_r.tag;
              epay_nxt[ia]  = cur_r.payload;
              cnt_nxt       = cnt_r + 1'b1;
              res_nxt.found = 1'b1;
              state_nxt     = S_EMIT;
            end
          end
          OP_CANCEL: begin
            if (in_range) begin
              idx_nxt = idx_r + 1'b1;
              if (key_match && etag_r[ia] == cur_r.tag) begin
                hold_nxt          = d_at;
                res_nxt.found     = 1'b1;
                res_nxt.time_left = (abs_sum[ACC_W-1:DELTA_W] != '0) ? '1
                                                                     : abs_sum[DELTA_W-1:0];
                state_nxt         = S_REMOVE;
              end else begin
                acc_nxt = abs_sum;
              end
            end else begin
              state_nxt = S_EMIT;
            end
          end
          OP_EXISTS: begin
            if (in_range) begin
              if (key_match && (cur_r.any || etag_r[ia] == cur_r.tag)) begin
                res_nxt.found = 1'b1;
                state_nxt     = S_EMIT;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end else begin
              state_nxt = S_EMIT;
            end
          end
          OP_COUNTS: begin
            if (in_range) begin
              if (ecore_r[ia]) res_nxt.count_core1 = res_r.count_core1 + 1'b1;
              else             res_nxt.count_core0 = res_r.count_core0 + 1'b1;
              if (etag_r[ia] == sleep_tag) res_nxt.count_sleep = res_r.count_sleep + 1'b1;
              idx_nxt = idx_r + 1'b1;
            end else begin
              res_nxt.count_total = cnt_r;
              state_nxt           = S_EMIT;
            end
          end
          default: state_nxt = S_EMIT;
        endcase
      end

      // Remove the matched entry; its delta folds into the next one.
      S_REMOVE: begin
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
          if (IDX_W'(j) >= rm) begin
            delta_nxt[j] = delta_r[j+1];
            ecore_nxt[j] = ecore_r[j+1];
            eid_nxt[j]   = eid_r[j+1];
            etag_nxt[j]  = etag_r[j+1];
            epay_nxt[j]  = epay_r[j+1];
          end
        end
        if (in_range) begin
          delta_nxt[rm] = pair_sum[DELTA_W] ? '1 : pair_sum[DELTA_W-1:0];
        end
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_EMIT;
      end

      // Hand the single result to the result queue.
      S_EMIT: begin
        res_valid = 1'b1;
        res_data  = res_r;
        if (!res_full) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      phase_r <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Datapath and list storage.
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    res_r   <= res_nxt;
    idx_r   <= idx_nxt;
    acc_r   <= acc_nxt;
    hold_r  <= hold_nxt;
    delta_r <= delta_nxt;
    ecore_r <= ecore_nxt;
    eid_r   <= eid_nxt;
    etag_r  <= etag_nxt;
    epay_r  <= epay_nxt;
  end

endmodule

// File: rtl/core/delta_list_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta list timer queue
// Time-ordered message queue for two cores with delta-coded entry times.
// ----------------------------------------------------------------------------
// Requests enter a two-deep request queue and results leave through a
// four-deep result queue, so both sides may stall independently. The engine
// handles one request at a time. A tick emits each expired entry in turn and
// then any periodic posts from S_PER0 and S_PER1. Schedule, cancel, exists
// and counts walk the list one entry per cycle; acknowledge goes straight to
// its result. Register 0 (byte address 0) holds the sleep handler tag used by
// the counts request.
module delta_list_timer_queue_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [dltq_pkg::CMD_W-1:0]     in_cmd,
  input  logic                           in_core,
  input  logic [dltq_pkg::DELTA_W-1:0]   in_delay_ms,
  input  logic [dltq_pkg::ID_W-1:0]      in_msg_id,
  input  logic [dltq_pkg::TAG_W-1:0]     in_handler_tag,
  input  logic [dltq_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic                           in_any_handler,
  output logic                           empty,
  input  logic                           pop,
  output logic [dltq_pkg::KIND_W-1:0]    out_kind,
  output logic                           out_core,
  output logic [dltq_pkg::ID_W-1:0]      out_msg_id,
  output logic [dltq_pkg::TAG_W-1:0]     out_handler_tag,
  output logic [dltq_pkg::PAYLOAD_W-1:0] out_payload,
  output logic [dltq_pkg::DELTA_W-1:0]   out_time_left,
  output logic                           out_found,
  output logic [dltq_pkg::CNT_W-1:0]     out_count_total,
  output logic [dltq_pkg::CNT_W-1:0]     out_count_core0,
  output logic [dltq_pkg::CNT_W-1:0]     out_count_core1,
  output logic [dltq_pkg::CNT_W-1:0]     out_count_sleep,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dltq_pkg::*;

  logic [TAG_W-1:0] sleep_tag_r;
  logic             req_valid, req_pop;
  req_t             req_data;
  logic             res_valid, res_full;
  res_t             res_data, res_head;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, sleep_tag_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleep_tag_r <= '0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      sleep_tag_r <= pwdata[TAG_W-1:0];
    end
  end

  dltq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_cmd         (in_cmd),
    .in_core        (in_core),
    .in_delay_ms    (in_delay_ms),
    .in_msg_id      (in_msg_id),
    .in_handler_tag (in_handler_tag),
    .in_payload     (in_payload),
    .in_any_handler (in_any_handler),
    .req_valid      (req_valid),
    .req_data       (req_data),
    .req_pop        (req_pop)
  );

  dltq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .sleep_tag (sleep_tag_r),
    .req_valid (req_valid),
    .req_data  (req_data),
    .req_pop   (req_pop),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  dltq_res_q u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .rd_data  (res_head)
  );

  // Result fields.
  assign out_kind        = res_head.kind;
  assign out_core        = res_head.core;
  assign out_msg_id      = res_head.msg_id;
  assign out_handler_tag = res_head.tag;
  assign out_payload     = res_head.payload;
  assign out_time_left   = res_head.time_left;
  assign out_found       = res_head.found;
  assign out_count_total = res_head.count_total;
  assign out_count_core0 = res_head.count_core0;
  assign out_count_core1 = res_head.count_core1;
  assign out_count_sleep = res_head.count_sleep;
  assign out_last        = res_head.last;

endmodule
